### hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types for the prime sieve: sequencer states and the cell control
// bundle that the sequencer drives into every sieve cell.
// ----------------------------------------------------------------------------
package pps_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // start: clear remainders, step: take one candidate bit,
    // shift: every cell takes its neighbor's prime (new prime enters cell 0)
    typedef struct packed
    {
        logic start;
        logic step;
        logic shift;
    } cell_ctrl_t;

endpackage

### hdl/pps_cell.sv
// ----------------------------------------------------------------------------
// pps_cell
// One sieve cell: holds one stored prime and a bit-serial remainder of the
// current candidate modulo that prime. The prime shifts to the next cell
// when a new prime is stored at the head of the chain.
// ----------------------------------------------------------------------------
module pps_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  pps_pkg::cell_ctrl_t   ctrl,
    input  logic                  bit_in,
    input  logic [VALUE_BITS-1:0] prime_in,
    output logic [VALUE_BITS-1:0] prime_out,
    output logic                  rem_zero
);

    logic [VALUE_BITS-1:0] prime_reg;
    logic [VALUE_BITS-1:0] prime_next;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // rem < prime, so the shifted trial is below twice the prime: one subtract
    always_comb
    begin
        trial = {rem_reg, bit_in};
        diff  = trial - {1'b0, prime_reg};
        if (ctrl.start)
        begin
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            if (trial >= {1'b0, prime_reg})
            begin
                rem_next = diff[VALUE_BITS-1:0];
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
            end
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    assign prime_next = ctrl.shift ? prime_in : prime_reg;

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        prime_reg <= prime_next;
    end

    assign prime_out = prime_reg;
    assign rem_zero  = (rem_reg == '0);

endmodule

### hdl/pipelined_prime_sieve.sv
// ----------------------------------------------------------------------------
// pipelined_prime_sieve
// Sequence: IDLE takes a candidate, RUN feeds its bits to every cell MSB
// first, DONE registers the result. Candidates are sieved one at a time,
// bit-serially in every cell, one candidate bit a cycle.
// Reset: asynchronous; clears the sequencer, output valid and stage count.
// Stored primes are not cleared; only filled stages are ever consulted.
// A finished result may wait in the output register while the next
// candidate is taken and sieved.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve #(
    parameter int MAX_STAGES = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  is_prime,
    output logic                  overflow,
    output logic                  end_of_run
);

    localparam int CNT_W = $clog2(MAX_STAGES + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);

    pps_pkg::state_t     state_reg;
    pps_pkg::state_t     state_next;
    pps_pkg::cell_ctrl_t ctrl;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [VALUE_BITS-1:0] shift_reg;
    logic [VALUE_BITS-1:0] shift_next;
    logic                  last_reg;
    logic                  last_next;
    logic [BIT_W-1:0]      bit_cnt_reg;
    logic [BIT_W-1:0]      bit_cnt_next;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] value_out_reg;
    logic [VALUE_BITS-1:0] value_out_next;
    logic                  is_prime_reg;
    logic                  is_prime_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  end_of_run_reg;
    logic                  end_of_run_next;

    logic                  in_xfer;
    logic                  finish;
    logic                  divisible;
    logic                  passes;
    logic                  full;
    logic                  store;

    logic [VALUE_BITS-1:0] prime_chain [MAX_STAGES+1];
    logic [MAX_STAGES-1:0] rem_zero;
    logic [MAX_STAGES-1:0] hit;

    // ---------------- sieve cells ----------------
    assign prime_chain[0] = value_reg;

    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_cell
        pps_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .bit_in    (shift_reg[VALUE_BITS-1]),
            .prime_in  (prime_chain[k]),
            .prime_out (prime_chain[k+1]),
            .rem_zero  (rem_zero[k])
        );
        assign hit[k] = rem_zero[k] && (CNT_W'(k) < used_reg);
    end

    assign divisible = |hit;
    assign full      = (used_reg == CNT_W'(MAX_STAGES));
    assign passes    = (value_reg >= VALUE_BITS'(2)) && !divisible;
    assign store     = finish && passes && !full;

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pps_pkg::ST_RUN;
                end
            end
            pps_pkg::ST_RUN:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = pps_pkg::ST_DONE;
                end
            end
            pps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        in_ready   = 1'b0;
        finish     = 1'b0;
        ctrl.start = 1'b0;
        ctrl.step  = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.start = 1'b1;
            end
            pps_pkg::ST_RUN:
            begin
                ctrl.step = 1'b1;
            end
            pps_pkg::ST_DONE:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        ctrl.shift = finish && passes && !full;
    end

    assign in_xfer = in_valid && in_ready;

    // ---------------- datapath ----------------
    always_comb
    begin
        value_next   = value_reg;
        shift_next   = shift_reg;
        last_next    = last_reg;
        bit_cnt_next = bit_cnt_reg;
        if (in_xfer)
        begin
            value_next   = value;
            shift_next   = value;
            last_next    = is_last;
            bit_cnt_next = BIT_W'(VALUE_BITS - 1);
        end
        else if (ctrl.step)
        begin
            shift_next   = {shift_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (finish)
        begin
            if (last_reg)
            begin
                used_next = '0;
            end
            else if (store)
            begin
                used_next = used_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        value_out_next  = value_out_reg;
        is_prime_next   = is_prime_reg;
        overflow_next   = overflow_reg;
        end_of_run_next = end_of_run_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (finish)
        begin
            out_valid_next  = 1'b1;
            value_out_next  = value_reg;
            is_prime_next   = passes && !full;
            overflow_next   = passes && full;
            end_of_run_next = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pps_pkg::ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        shift_reg      <= shift_next;
        last_reg       <= last_next;
        bit_cnt_reg    <= bit_cnt_next;
        value_out_reg  <= value_out_next;
        is_prime_reg   <= is_prime_next;
        overflow_reg   <= overflow_next;
        end_of_run_reg <= end_of_run_next;
    end

    assign out_valid  = out_valid_reg;
    assign value_out  = value_out_reg;
    assign is_prime   = is_prime_reg;
    assign overflow   = overflow_reg;
    assign end_of_run = end_of_run_reg;

    // ---------------- assertions ----------------
    a_prime_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_prime && overflow))
        else $error("is_prime and overflow both set");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_STAGES))
        else $error("stage count beyond chain length");

    a_run_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == pps_pkg::ST_RUN) && (bit_cnt_reg == BIT_W'(VALUE_BITS - 1)))
        else $error("sieve did not start after input transfer");

    a_prime_ge2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_prime) |-> (value_out >= VALUE_BITS'(2)))
        else $error("value below two reported prime");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && last_reg) |=> (used_reg == '0) && out_valid && end_of_run)
        else $error("stages not cleared at end of run");

endmodule
